### hdl/mtsb_pkg.sv
package mtsb_pkg;

   // Defaults for the top level parameters
   localparam int unsigned PHASE_BITS_DEFAULT       = 24;
   localparam int unsigned NOTE_TABLE_DEPTH_DEFAULT = 256;

   // Depth of the queue between the classifier and the write sequencer
   localparam int unsigned QUEUE_DEPTH = 4;

   // Words the synth takes for one phase increment plus gate
   localparam int unsigned NOTE_BEATS = 4;

   // Width of the phase increment that goes out on the register bus
   localparam int unsigned SENT_BITS = 24;

   // MIDI message kinds (upper nibble of the status byte)
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_CONTROL  = 4'hB;

   // Controller numbers
   localparam logic [7:0] CC_PWM     = 8'd1;
   localparam logic [7:0] CC_WAVE    = 8'd2;
   localparam logic [7:0] CC_ATTACK  = 8'd3;
   localparam logic [7:0] CC_DECAY   = 8'd4;
   localparam logic [7:0] CC_SUSTAIN = 8'd5;
   localparam logic [7:0] CC_RELEASE = 8'd6;
   localparam logic [7:0] CC_LOOP    = 8'd7;
   localparam logic [7:0] CC_CURVE   = 8'd8;

   // Synth register map
   localparam logic [7:0] ADDR_PHASE_LO  = 8'h00;
   localparam logic [7:0] ADDR_PHASE_MID = 8'h01;
   localparam logic [7:0] ADDR_PHASE_HI  = 8'h02;
   localparam logic [7:0] ADDR_WAVE      = 8'h03;
   localparam logic [7:0] ADDR_PWM       = 8'h04;
   localparam logic [7:0] ADDR_ENV_CTRL  = 8'h40;
   localparam logic [7:0] ADDR_ATTACK    = 8'h41;
   localparam logic [7:0] ADDR_DECAY     = 8'h42;
   localparam logic [7:0] ADDR_SUSTAIN   = 8'h43;
   localparam logic [7:0] ADDR_RELEASE   = 8'h44;
   localparam logic [7:0] ADDR_GATE      = 8'h45;

   localparam logic [7:0] ENV_CTRL_RESET = 8'h01;
   localparam logic [7:0] WAVE_MAX       = 8'd5;

   typedef enum logic {
      CMD_SINGLE,
      CMD_NOTE_ON
   } cmd_kind_type;

   // One classified message waiting for the write sequencer
   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           addr;
      logic [7:0]           value;
      logic [SENT_BITS-1:0] word;
   } cmd_type;

   // 2^(s/12) scaled by 10^15, truncated
   localparam longint unsigned SEMI_RATIO [12] = '{
      64'd1000000000000000, 64'd1059463094359295, 64'd1122462048309373,
      64'd1189207115002721, 64'd1259921049894873, 64'd1334839854170034,
      64'd1414213562373095, 64'd1498307076876681, 64'd1587401051968199,
      64'd1681792830507429, 64'd1781797436280678, 64'd1887748625363386
   };
   localparam longint unsigned SEMI_DEN = 64'd11444091796875;

   // Rounded DDS increment for one note, saturated to the phase width.
   // Evaluated at elaboration only.
   function automatic logic [31:0] note_increment(input int unsigned note,
                                                  input int unsigned phase_bits);
      int unsigned     idx;
      int              octave;
      int              e;
      int              k;
      int              i;
      longint unsigned a;
      longint unsigned q;
      longint unsigned r;
      longint unsigned lim;
      longint unsigned rem;
      logic            done;
      idx    = note + 3;
      octave = int'(idx / 12) - 6;
      a      = 64'd11 * SEMI_RATIO[idx % 12];
      e      = int'(phase_bits) - 20 + octave;
      lim    = (64'd1 << phase_bits) - 64'd1;
      q      = a / SEMI_DEN;
      r      = a % SEMI_DEN;
      done   = 1'b0;
      if (e < 0) begin
         k   = -e;
         rem = ((q & ((64'd1 << k) - 64'd1)) * SEMI_DEN) + r;
         q   = q >> k;
         if ((64'd2 * rem) >= (SEMI_DEN << k)) begin
            q = q + 64'd1;
         end
      end else begin
         for (i = 0; i < e; i++) begin
            if (!done) begin
               q = q << 1;
               r = r << 1;
               if (r >= SEMI_DEN) begin
                  r = r - SEMI_DEN;
                  q = q + 64'd1;
               end
               if (q > lim) begin
                  done = 1'b1;
               end
            end
         end
         if (!done && ((64'd2 * r) >= SEMI_DEN)) begin
            q = q + 64'd1;
         end
      end
      if (done || (q > lim)) begin
         q = lim;
      end
      return q[31:0];
   endfunction

endpackage

### hdl/mtsb_front.sv
module mtsb_front #(
   parameter int unsigned PHASE_BITS       = mtsb_pkg::PHASE_BITS_DEFAULT,
   parameter int unsigned NOTE_TABLE_DEPTH = mtsb_pkg::NOTE_TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_status_byte,
   input  logic [7:0]       req_first_data,
   input  logic [7:0]       req_second_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output mtsb_pkg::cmd_type cmd
);
   import mtsb_pkg::*;

   localparam int unsigned IdxBits = $clog2(NOTE_TABLE_DEPTH);
   localparam logic [PHASE_BITS-1:0] MaxWord = '1;

   logic [PHASE_BITS-1:0] rom_table [NOTE_TABLE_DEPTH];

   for (genvar n = 0; n < NOTE_TABLE_DEPTH; n++) begin : g_rom
      localparam logic [31:0] Inc = note_increment(n, PHASE_BITS);
      assign rom_table[n] = Inc[PHASE_BITS-1:0];
   end

   logic                  cmd_valid_ff, cmd_valid_in;
   cmd_type               cmd_ff, cmd_in;
   logic [7:0]            env_ff, env_in;
   logic                  accept;
   logic                  has_write;
   logic                  beyond_rom;
   logic [PHASE_BITS-1:0] rom_word;
   logic [31:0]           word_wide;
   logic [SENT_BITS-1:0]  sent_word;
   logic [7:0]            doubled;
   logic [7:0]            wave;
   logic [1:0]            curve;
   logic [3:0]            kind;

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign kind      = req_status_byte[7:4];

   // Phase word: notes past the ROM take the full-scale word
   assign beyond_rom = {1'b0, req_first_data} >= 9'(NOTE_TABLE_DEPTH);
   assign rom_word   = beyond_rom ? MaxWord : rom_table[req_first_data[IdxBits-1:0]];
   assign word_wide  = 32'(rom_word);
   assign sent_word  = (word_wide > 32'(2**SENT_BITS - 1)) ? '1 : word_wide[SENT_BITS-1:0];

   // Controller value scaling
   assign doubled = req_second_data[7] ? 8'hFF : {req_second_data[6:0], 1'b0};
   assign curve   = req_second_data[7] ? 2'd3 : req_second_data[6:5];

   always_comb begin
      if (req_second_data >= 8'd110)      wave = WAVE_MAX;
      else if (req_second_data >= 8'd88)  wave = 8'd4;
      else if (req_second_data >= 8'd66)  wave = 8'd3;
      else if (req_second_data >= 8'd44)  wave = 8'd2;
      else if (req_second_data >= 8'd22)  wave = 8'd1;
      else                                wave = 8'd0;
   end

   always_comb begin
      has_write    = 1'b0;
      env_in       = env_ff;
      cmd_in.kind  = CMD_SINGLE;
      cmd_in.addr  = ADDR_GATE;
      cmd_in.value = 8'd0;
      cmd_in.word  = sent_word;
      unique case (kind)
         STATUS_NOTE_ON: begin
            has_write = 1'b1;
            if (req_second_data != 8'd0) begin
               cmd_in.kind = CMD_NOTE_ON;
            end
         end
         STATUS_NOTE_OFF: begin
            has_write = 1'b1;
         end
         STATUS_CONTROL: begin
            has_write = 1'b1;
            unique case (req_first_data)
               CC_PWM: begin
                  cmd_in.addr  = ADDR_PWM;
                  cmd_in.value = doubled;
               end
               CC_WAVE: begin
                  cmd_in.addr  = ADDR_WAVE;
                  cmd_in.value = wave;
               end
               CC_ATTACK: begin
                  cmd_in.addr  = ADDR_ATTACK;
                  cmd_in.value = doubled;
               end
               CC_DECAY: begin
                  cmd_in.addr  = ADDR_DECAY;
                  cmd_in.value = doubled;
               end
               CC_SUSTAIN: begin
                  cmd_in.addr  = ADDR_SUSTAIN;
                  cmd_in.value = doubled;
               end
               CC_RELEASE: begin
                  cmd_in.addr  = ADDR_RELEASE;
                  cmd_in.value = doubled;
               end
               CC_LOOP: begin
                  env_in[2]    = req_second_data[7] | req_second_data[6];
                  cmd_in.addr  = ADDR_ENV_CTRL;
                  cmd_in.value = env_in;
               end
               CC_CURVE: begin
                  env_in[5:4]  = curve;
                  cmd_in.addr  = ADDR_ENV_CTRL;
                  cmd_in.value = env_in;
               end
               default: begin
                  has_write = 1'b0;
               end
            endcase
         end
         default: begin
            has_write = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         cmd_valid_in = has_write;
      end else if (cmd_ready) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         env_ff       <= ENV_CTRL_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         if (accept) begin
            env_ff <= env_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

   a_env_bit0: assert property (@(posedge clock) disable iff (reset) env_ff[0])
      else $error("envelope control lost its enable bit");
   a_hold_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff && !cmd_ready |=> cmd_valid_ff && $stable(cmd_ff))
      else $error("pending command changed before the queue took it");

endmodule

### hdl/mtsb_queue.sv
module mtsb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mtsb_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mtsb_pkg::cmd_type pop_cmd
);
   import mtsb_pkg::*;

   localparam int unsigned PtrBits   = $clog2(QUEUE_DEPTH);
   localparam int unsigned CountBits = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != CountBits'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PtrBits'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? PtrBits'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

### hdl/mtsb_back.sv
module mtsb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mtsb_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_reg_address,
   output logic [7:0]        rsp_reg_value,
   output logic              rsp_last_write
);
   import mtsb_pkg::*;

   localparam int unsigned BeatBits = $clog2(NOTE_BEATS);
   localparam logic [BeatBits-1:0] LastBeat = BeatBits'(NOTE_BEATS - 1);

   logic [BeatBits-1:0] beat_ff, beat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          addr_ff, addr_in;
   logic [7:0]          value_ff, value_in;
   logic                last_ff, last_in;
   logic                load;

   assign load      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = load && last_in;

   // Pick the word for the current beat of the head command
   always_comb begin
      addr_in  = cmd.addr;
      value_in = cmd.value;
      last_in  = 1'b1;
      if (cmd.kind == CMD_NOTE_ON) begin
         last_in = beat_ff == LastBeat;
         case (beat_ff)
            BeatBits'(0): begin
               addr_in  = ADDR_PHASE_LO;
               value_in = cmd.word[7:0];
            end
            BeatBits'(1): begin
               addr_in  = ADDR_PHASE_MID;
               value_in = cmd.word[15:8];
            end
            BeatBits'(2): begin
               addr_in  = ADDR_PHASE_HI;
               value_in = cmd.word[23:16];
            end
            default: begin
               addr_in  = ADDR_GATE;
               value_in = 8'd1;
            end
         endcase
      end
   end

   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = last_in ? '0 : beat_ff + 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff  <= addr_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_address = addr_ff;
   assign rsp_reg_value   = value_ff;
   assign rsp_last_write  = last_ff;

   a_beat_note: assert property (@(posedge clock) disable iff (reset)
      beat_ff != '0 |-> cmd_valid && cmd.kind == CMD_NOTE_ON)
      else $error("beat count running without a note command at the head");

endmodule

### hdl/midi_to_synth_register_bridge.sv
// MIDI to synthesizer register bridge.
//
// Input channel (req_*): one MIDI message per word, status byte plus two data
// bytes; the channel nibble is ignored. Output channel (rsp_*): synth register
// writes, address and value, with rsp_last_write marking the final write that
// a message causes. Note On with nonzero velocity gives four words (phase
// increment low, mid, high, then gate on); Note Off and zero-velocity Note On
// give gate off; controllers 1 to 8 give one word; anything else gives none.
//
// Path: a taken message passes the classify register, the queue slot and the
// output register before rsp_valid rises. Throughput: one write per cycle at
// the output register while the receiver holds rsp_ready high, so a Note On
// takes four writes in a row and any other message one; messages keep being
// taken while writes drain, until the four-entry command queue fills.
//
// Reset (synchronous) empties the queue, drops any pending write and sets the
// envelope control byte to 0x01. When the receiver stalls, the current write
// holds on rsp_*, the queue fills, and req_ready then drops.
module midi_to_synth_register_bridge #(
   parameter int unsigned PHASE_BITS       = mtsb_pkg::PHASE_BITS_DEFAULT,
   parameter int unsigned NOTE_TABLE_DEPTH = mtsb_pkg::NOTE_TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_status_byte,
   input  logic [7:0] req_first_data,
   input  logic [7:0] req_second_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_reg_address,
   output logic [7:0] rsp_reg_value,
   output logic       rsp_last_write
);
   import mtsb_pkg::*;

   // Classified command from the front, before the queue
   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;

   // Head of the queue, toward the write sequencer
   logic    head_valid;
   logic    head_ready;
   cmd_type head_cmd;

   // Decode the message, look up the phase increment, track envelope control
   mtsb_front #(
      .PHASE_BITS       (PHASE_BITS),
      .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_status_byte (req_status_byte),
      .req_first_data  (req_first_data),
      .req_second_data (req_second_data),
      .cmd_valid       (front_valid),
      .cmd_ready       (front_ready),
      .cmd             (front_cmd)
   );

   // Buffer commands so the decoder and the write sequencer stall apart
   mtsb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_cmd    (head_cmd)
   );

   // Emit one register write per cycle from the head command while the receiver is ready
   mtsb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (head_valid),
      .cmd_ready       (head_ready),
      .cmd             (head_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_last_write  (rsp_last_write)
   );

endmodule

### dv/tb_midi_to_synth_register_bridge.sv
module tb_midi_to_synth_register_bridge;
   timeunit 1ns;
   timeprecision 1ps;

   import mtsb_pkg::*;

   localparam time         HALF_PERIOD  = 10ns;
   localparam int unsigned PHASE_W      = PHASE_BITS_DEFAULT;
   localparam int unsigned NOTE_DEPTH   = NOTE_TABLE_DEPTH_DEFAULT;
   localparam int          LIMIT_CYCLES = 200000;
   // Cycles to watch after the last write: classify, queue and output register
   // plus some slack
   localparam int          TAIL_CYCLES  = 12;

   // Message kinds the bridge ignores
   localparam logic [3:0]  STATUS_SYSTEM  = 4'hF;
   localparam logic [3:0]  STATUS_UNKNOWN = 4'h0;
   // Controller numbers outside the mapped range
   localparam logic [7:0]  CC_UNMAPPED_LO = 8'd0;
   localparam logic [7:0]  CC_UNMAPPED_HI = 8'd255;

   // Envelope control layout: bit 2 loop, bits 5:4 curve model
   localparam int          ENV_LOOP_BIT  = 2;
   localparam int          ENV_CURVE_LSB = 4;

   typedef struct packed {
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
   } midi_msg_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] value;
      logic       last;
   } synth_write_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_status_byte = 8'h00;
   logic [7:0] req_first_data  = 8'h00;
   logic [7:0] req_second_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [7:0] rsp_reg_address;
   logic [7:0] rsp_reg_value;
   logic       rsp_last_write;

   midi_msg_type    midi_backlog[$];     // messages waiting to go out on req_*
   synth_write_type synth_writes_due[$]; // register writes owed by the bridge
   logic [31:0]     phase_incr_rom[NOTE_DEPTH];
   logic [7:0]      env_ctrl_shadow = ENV_CTRL_RESET;

   logic req_taken      = 1'b0;
   bit   steady_stretch = 1'b0;
   int   msgs_queued    = 0;
   int   msgs_taken     = 0;
   int   cycle_count    = 0;
   int   failures       = 0;
   int   writes_checked = 0;
   int   n_note_on      = 0;
   int   n_gate_off     = 0;
   int   n_controller   = 0;
   int   n_ignored      = 0;

   midi_to_synth_register_bridge dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_status_byte (req_status_byte),
      .req_first_data  (req_first_data),
      .req_second_data (req_second_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_last_write  (rsp_last_write)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Increment = 440 * 2^((n-69)/12) * 2^PHASE_W / 480000. Since 440/480000 is
   // 11/12000 and 12000*10^15 = SEMI_DEN * 2^20, this becomes
   // 11 * ratio[(n+3) mod 12] * 2^(PHASE_W - 20 + octave) / SEMI_DEN, where
   // octave = (n+3)/12 - 6. Do it in 128 bits and round half up.
   function automatic logic [31:0] phase_increment(input int unsigned note);
      int unsigned  pos;
      int           shift;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic [127:0] ceiling;
      pos     = note + 3;
      shift   = int'(PHASE_W) - 20 + (int'(pos / 12) - 6);
      num     = 128'(11) * 128'(SEMI_RATIO[pos % 12]);
      den     = 128'(SEMI_DEN);
      if (shift >= 0) begin
         num = num << shift;
      end else begin
         den = den << (-shift);
      end
      q       = (2 * num + den) / (2 * den);
      ceiling = (128'd1 << PHASE_W) - 128'd1;
      if (q > ceiling) begin
         q = ceiling;
      end
      return q[31:0];
   endfunction

   function automatic logic [7:0] doubled_sat(input logic [7:0] v);
      return v[7] ? 8'hFF : {v[6:0], 1'b0};
   endfunction

   task automatic owe_write(input logic [7:0] addr, input logic [7:0] value,
                            input logic last);
      synth_write_type w;
      w.addr  = addr;
      w.value = value;
      w.last  = last;
      synth_writes_due.push_back(w);
   endtask

   // Work out the register writes one accepted message causes
   task automatic translate_message(input midi_msg_type m);
      logic [31:0] word;
      logic [7:0]  wave;
      logic [7:0]  curve;
      if (m.status[7:4] == STATUS_NOTE_ON && m.second != 8'd0) begin
         word = (m.first < NOTE_DEPTH) ? phase_incr_rom[m.first]
                                       : 32'((64'd1 << PHASE_W) - 64'd1);
         // Only SENT_BITS go out; clip anything wider
         if (word > ((32'd1 << SENT_BITS) - 32'd1)) begin
            word = (32'd1 << SENT_BITS) - 32'd1;
         end
         owe_write(ADDR_PHASE_LO,  word[7:0],   1'b0);
         owe_write(ADDR_PHASE_MID, word[15:8],  1'b0);
         owe_write(ADDR_PHASE_HI,  word[23:16], 1'b0);
         owe_write(ADDR_GATE,      8'd1,        1'b1);
         n_note_on++;
      end else if (m.status[7:4] == STATUS_NOTE_ON || m.status[7:4] == STATUS_NOTE_OFF) begin
         owe_write(ADDR_GATE, 8'd0, 1'b1);
         n_gate_off++;
      end else if (m.status[7:4] == STATUS_CONTROL) begin
         n_controller++;
         case (m.first)
            CC_PWM:     owe_write(ADDR_PWM,     doubled_sat(m.second), 1'b1);
            CC_ATTACK:  owe_write(ADDR_ATTACK,  doubled_sat(m.second), 1'b1);
            CC_DECAY:   owe_write(ADDR_DECAY,   doubled_sat(m.second), 1'b1);
            CC_SUSTAIN: owe_write(ADDR_SUSTAIN, doubled_sat(m.second), 1'b1);
            CC_RELEASE: owe_write(ADDR_RELEASE, doubled_sat(m.second), 1'b1);
            CC_WAVE: begin
               wave = m.second / 8'd22;
               if (wave > WAVE_MAX) begin
                  wave = WAVE_MAX;
               end
               owe_write(ADDR_WAVE, wave, 1'b1);
            end
            CC_LOOP: begin
               env_ctrl_shadow[ENV_LOOP_BIT] = (m.second >= 8'd64);
               owe_write(ADDR_ENV_CTRL, env_ctrl_shadow, 1'b1);
            end
            CC_CURVE: begin
               curve = m.second / 8'd32;
               if (curve > 8'd3) begin
                  curve = 8'd3;
               end
               env_ctrl_shadow[ENV_CURVE_LSB +: 2] = curve[1:0];
               owe_write(ADDR_ENV_CTRL, env_ctrl_shadow, 1'b1);
            end
            default: begin
               n_controller--;
               n_ignored++;
            end
         endcase
      end else begin
         n_ignored++;
      end
   endtask

   function automatic bit take_break();
      return !steady_stretch && ($urandom_range(0, 99) < 28);
   endfunction

   // Request driver: present the next message from the backlog at the falling
   // edge, and hold it until the bridge takes it.
   always @(negedge clock) begin : drive_req
      midi_msg_type m;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (midi_backlog.size() != 0 && !take_break()) begin
            m = midi_backlog.pop_front();
            req_valid       <= 1'b1;
            req_status_byte <= m.status;
            req_first_data  <= m.first;
            req_second_data <= m.second;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Write receiver: stall at random, except during the steady stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_break();
      end
   end

   // Monitor: check finished writes first, then book what a newly taken
   // message owes, so a stray write never matches a fresh expectation.
   always @(posedge clock) begin : watch_bus
      synth_write_type w;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (synth_writes_due.size() == 0) begin
               $error("unexpected write: reg_address=%02h reg_value=%02h last_write=%0b",
                      rsp_reg_address, rsp_reg_value, rsp_last_write);
               failures++;
            end else begin
               w = synth_writes_due.pop_front();
               writes_checked++;
               if (rsp_reg_address !== w.addr) begin
                  $error("reg_address: expected %02h, got %02h", w.addr, rsp_reg_address);
                  failures++;
               end
               if (rsp_reg_value !== w.value) begin
                  $error("reg_value: expected %02h, got %02h", w.value, rsp_reg_value);
                  failures++;
               end
               if (rsp_last_write !== w.last) begin
                  $error("last_write: expected %0b, got %0b", w.last, rsp_last_write);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            translate_message({req_status_byte, req_first_data, req_second_data});
            msgs_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_message(input logic [3:0] kind, input logic [7:0] first,
                                input logic [7:0] second);
      midi_msg_type m;
      // Channel nibble is don't-care for the bridge; randomize it
      m.status = {kind, 4'($urandom_range(0, 15))};
      m.first  = first;
      m.second = second;
      midi_backlog.push_back(m);
      msgs_queued++;
   endtask

   // Hold until every queued message is taken and every write has come back
   task automatic wait_for_quiet();
      do begin
         @(negedge clock);
      end while (msgs_taken != msgs_queued || synth_writes_due.size() != 0);
   endtask

   // Queue random traffic until `count` messages that cause writes are in;
   // ignored kinds and unmapped controllers come along as noise.
   task automatic queue_random(input int count);
      int         useful;
      int         pick;
      logic [3:0] kind;
      logic [7:0] first;
      logic [7:0] second;
      useful = 0;
      while (useful < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            kind   = STATUS_NOTE_ON;
            first  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 127))
                                                : 8'($urandom_range(0, 255));
            second = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            useful++;
         end else if (pick < 50) begin
            kind   = STATUS_NOTE_OFF;
            first  = 8'($urandom_range(0, 255));
            second = 8'($urandom_range(0, 255));
            useful++;
         end else if (pick < 90) begin
            kind   = STATUS_CONTROL;
            first  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(CC_PWM, CC_CURVE))
                                                : 8'($urandom_range(0, 255));
            second = 8'($urandom_range(0, 255));
            if (first >= CC_PWM && first <= CC_CURVE) begin
               useful++;
            end
         end else begin
            do begin
               kind = 4'($urandom_range(0, 15));
            end while (kind == STATUS_NOTE_ON || kind == STATUS_NOTE_OFF ||
                       kind == STATUS_CONTROL);
            first  = 8'($urandom_range(0, 255));
            second = 8'($urandom_range(0, 255));
         end
         queue_message(kind, first, second);
      end
   endtask

   initial begin
      for (int n = 0; n < NOTE_DEPTH; n++) begin
         phase_incr_rom[n] = phase_increment(n);
      end

      // Directed: lowest and highest notes, the saturation knee, zero
      // velocity, every controller at its scaling edges, ignored traffic.
      queue_message(STATUS_NOTE_ON,  8'd0,       8'd1);
      queue_message(STATUS_NOTE_ON,  8'd69,      8'd127);
      queue_message(STATUS_NOTE_ON,  8'd127,     8'd255);
      queue_message(STATUS_NOTE_ON,  8'd190,     8'd64);
      queue_message(STATUS_NOTE_ON,  8'd191,     8'd128);
      queue_message(STATUS_NOTE_ON,  8'd255,     8'd255);
      queue_message(STATUS_NOTE_ON,  8'd60,      8'd0);
      queue_message(STATUS_NOTE_OFF, 8'd60,      8'd255);
      queue_message(STATUS_NOTE_OFF, 8'd0,       8'd0);
      queue_message(STATUS_CONTROL,  CC_PWM,     8'd127);
      queue_message(STATUS_CONTROL,  CC_PWM,     8'd128);
      queue_message(STATUS_CONTROL,  CC_WAVE,    8'd255);
      queue_message(STATUS_CONTROL,  CC_WAVE,    8'd21);
      queue_message(STATUS_CONTROL,  CC_ATTACK,  8'd0);
      queue_message(STATUS_CONTROL,  CC_DECAY,   8'd255);
      queue_message(STATUS_CONTROL,  CC_SUSTAIN, 8'd127);
      queue_message(STATUS_CONTROL,  CC_RELEASE, 8'd200);
      queue_message(STATUS_CONTROL,  CC_LOOP,    8'd64);
      queue_message(STATUS_CONTROL,  CC_LOOP,    8'd63);
      queue_message(STATUS_CONTROL,  CC_CURVE,   8'd255);
      queue_message(STATUS_CONTROL,  CC_CURVE,   8'd95);
      queue_message(STATUS_CONTROL,  CC_UNMAPPED_LO, 8'd100);
      queue_message(STATUS_CONTROL,  CC_UNMAPPED_HI, 8'd100);
      queue_message(STATUS_SYSTEM,   8'd255,     8'd255);
      queue_message(STATUS_UNKNOWN,  8'd0,       8'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain fully between phases; push only at the rising edge so the
      // driver never races the backlog.
      wait_for_quiet();
      @(posedge clock);
      queue_random(66);

      wait_for_quiet();
      @(posedge clock);
      steady_stretch = 1'b1;
      queue_random(44);

      wait_for_quiet();
      @(posedge clock);
      steady_stretch = 1'b0;
      queue_random(44);

      wait_for_quiet();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d note-on, %0d gate-off, %0d controller and %0d ignored messages;",
               n_note_on, n_gate_off, n_controller, n_ignored);
      $display("checked %0d register writes under random stalls on both sides.",
               writes_checked);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
